@@ rtl/ds_twr_responder_ranging_assert.svh @@
// Assertion macros for the DS-TWR responder ranging block.
// Uses the clock and reset names of the including module.
`ifndef DS_TWR_RESPONDER_RANGING_ASSERT_SVH
`define DS_TWR_RESPONDER_RANGING_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DSTWR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DSTWR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dstwr_pkg.sv @@
// Package for the DS-TWR responder: field widths, codes and shared types.
// No dependencies.
`default_nettype none

package dstwr_pkg;

   localparam int TS_W       = 40;
   localparam int T32_W      = 32;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 3;
   localparam int SEQ_W      = 8;
   localparam int PROD_W     = 2 * T32_W;
   localparam int DEN_W      = T32_W + 2;
   localparam int MUL_CNT_W  = $clog2(T32_W);
   localparam int DIV_CNT_W  = $clog2(PROD_W);
   localparam int SCHED_LSB  = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
   localparam logic [OP_W-1:0] OP_FINAL = 2'd1;
   localparam logic [OP_W-1:0] OP_BAD   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FAILED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RANGE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INVALID = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

   // register index of response_delay_ticks
   localparam logic [CSR_ADDR_W-3:0] REG_DELAY = 1'd0;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_stat_type;

endpackage

`default_nettype wire

@@ rtl/dstwr_req_if.sv @@
// Request channel of the DS-TWR responder: valid/ready plus frame fields.
// Depends on dstwr_pkg.
`default_nettype none

interface dstwr_req_if import dstwr_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [TS_W-1:0]   rx_timestamp;
   logic [TS_W-1:0]   response_tx_timestamp;
   logic [T32_W-1:0]  initiator_poll_tx;
   logic [T32_W-1:0]  initiator_resp_rx;
   logic [T32_W-1:0]  initiator_final_tx;
   logic              transmit_accepted;

   modport source (
      output valid, operation, rx_timestamp, response_tx_timestamp,
             initiator_poll_tx, initiator_resp_rx, initiator_final_tx,
             transmit_accepted,
      input  ready
   );

   modport sink (
      input  valid, operation, rx_timestamp, response_tx_timestamp,
             initiator_poll_tx, initiator_resp_rx, initiator_final_tx,
             transmit_accepted,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/dstwr_rsp_if.sv @@
// Response channel of the DS-TWR responder: valid/ready plus result fields.
// Depends on dstwr_pkg.
`default_nettype none

interface dstwr_rsp_if import dstwr_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        result_kind;
   logic [T32_W-1:0]         scheduled_tx_time;
   logic [SEQ_W-1:0]         response_sequence;
   logic signed [T32_W-1:0]  flight_time_ticks;
   logic                     expecting_final;

   modport source (
      output valid, result_kind, scheduled_tx_time, response_sequence,
             flight_time_ticks, expecting_final,
      input  ready
   );

   modport sink (
      input  valid, result_kind, scheduled_tx_time, response_sequence,
             flight_time_ticks, expecting_final,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/dstwr_mult.sv @@
// Bit-serial 32x32 unsigned shift-add multiplier, one multiplier bit a cycle.
// Depends on dstwr_pkg.
`default_nettype none

module dstwr_mult import dstwr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [T32_W-1:0]    mcand,
   input  logic [T32_W-1:0]    mplier,
   output logic [PROD_W-1:0]   product,
   output serial_stat_type     stat
);

   logic [T32_W-1:0]     mcand_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [T32_W:0]       partial;

   // upper half accumulates, lower half shifts the multiplier out
   assign partial = {1'b0, prod_ff[PROD_W-1:T32_W]}
                  + {1'b0, (prod_ff[0] ? mcand_ff : '0)};

   always_comb begin
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = {{T32_W{1'b0}}, mplier};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[T32_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(T32_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= prod_in;
      if (start) begin
         mcand_ff <= mcand;
      end
   end

   assign product   = prod_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ rtl/dstwr_div.sv @@
// Restoring bit-serial divider: 64-bit dividend by 34-bit divisor, one
// quotient bit a cycle. Depends on dstwr_pkg.
`default_nettype none

module dstwr_div import dstwr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [DEN_W-1:0]    divisor,
   output logic [PROD_W-1:0]   quotient,
   output serial_stat_type     stat
);

   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = !diff[DEN_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits back in DEN_W bits
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ rtl/ds_twr_responder_ranging.sv @@
// DS-TWR responder ranging. A poll or bad-frame request is resolved in the
// cycle it is accepted and held in the pending result registers; the FINISH
// state then moves it into the output register, and the next request is
// taken once the sequencer is back in IDLE. A final request runs through
// the serial datapath: the denominator is formed while both bit-serial
// multipliers load, 32 multiply steps follow (Ra*Rb and Da*Db side by side),
// the multipliers flag done, the numerator magnitude is formed while the
// divider loads, 64 divide steps follow, the divider flags done and the
// quotient is saturated, and the result moves into the output register. A
// zero denominator skips the divide and gives an invalid result. One
// request is worked at a time; a finished response waits in an output
// register, so the next request is taken while the previous one is unread.
// If the output register is still full, the finished result waits and the
// input stalls.
// Depends on dstwr_pkg, dstwr_req_if, dstwr_rsp_if, dstwr_mult, dstwr_div
// and the assertion macro header.
`default_nettype none
`include "ds_twr_responder_ranging_assert.svh"

module ds_twr_responder_ranging import dstwr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   dstwr_req_if.sink              req_chan,
   dstwr_rsp_if.source            rsp_chan,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_PREP   = 3'd1;
   localparam logic [ST_W-1:0] ST_MUL    = 3'd2;
   localparam logic [ST_W-1:0] ST_SUB    = 3'd3;
   localparam logic [ST_W-1:0] ST_DIV    = 3'd4;
   localparam logic [ST_W-1:0] ST_FINISH = 3'd5;

   logic [ST_W-1:0]   state_ff, state_in;

   // architectural state
   logic [T32_W-1:0]  delay_ff;
   logic [T32_W-1:0]  poll_low_ff, poll_low_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic              awaiting_ff, awaiting_in;

   // intervals and denominator of the current final request
   logic [T32_W-1:0]  ra_ff, rb_ff, da_ff, db_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              neg_ff;

   // pending result, then output register
   logic [KIND_W-1:0] res_kind_ff, res_kind_in;
   logic [T32_W-1:0]  res_sched_ff, res_sched_in;
   logic [SEQ_W-1:0]  res_seq_ff, res_seq_in;
   logic [T32_W-1:0]  res_tof_ff, res_tof_in;
   logic              res_expect_ff, res_expect_in;

   logic              out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] out_kind_ff;
   logic [T32_W-1:0]  out_sched_ff;
   logic [SEQ_W-1:0]  out_seq_ff;
   logic [T32_W-1:0]  out_tof_ff;
   logic              out_expect_ff;

   logic              accept;
   logic              poll_sent;
   logic              out_load;
   logic              csr_write;
   logic [TS_W-1:0]   sched_sum;
   logic [T32_W-1:0]  rx32, tx32;
   logic [PROD_W-1:0] prod_ab, prod_cd, mag;
   logic              prod_neg;
   logic [PROD_W-1:0] quo;
   logic [T32_W-1:0]  tof_sat;
   logic              mul_busy;
   serial_stat_type   mul_ab_stat, mul_cd_stat, div_stat;

   // ---------------------------------------------------------------- csr
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                   && (paddr[CSR_ADDR_W-1:2] == REG_DELAY);
   assign prdata    = (paddr[CSR_ADDR_W-1:2] == REG_DELAY) ? delay_ff : '0;

   // ---------------------------------------------------------------- datapath
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign poll_sent      = accept && (req_chan.operation == OP_POLL)
                        && req_chan.transmit_accepted;

   // delayed tx time: 40-bit device clock wraps, keep bits 39..8
   assign sched_sum = req_chan.rx_timestamp + {{(TS_W-T32_W){1'b0}}, delay_ff};
   assign rx32      = req_chan.rx_timestamp[T32_W-1:0];
   assign tx32      = req_chan.response_tx_timestamp[T32_W-1:0];

   dstwr_mult u_mul_ab (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_PREP),
      .mcand   (ra_ff),
      .mplier  (rb_ff),
      .product (prod_ab),
      .stat    (mul_ab_stat)
   );

   dstwr_mult u_mul_cd (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_PREP),
      .mcand   (da_ff),
      .mplier  (db_ff),
      .product (prod_cd),
      .stat    (mul_cd_stat)
   );

   assign mul_busy = mul_ab_stat.busy || mul_cd_stat.busy;

   // sign and magnitude of Ra*Rb - Da*Db
   assign prod_neg = prod_ab < prod_cd;
   assign mag      = prod_neg ? (prod_cd - prod_ab) : (prod_ab - prod_cd);

   dstwr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SUB),
      .dividend (mag),
      .divisor  (den_ff),
      .quotient (quo),
      .stat     (div_stat)
   );

   // saturate to signed 32 bits; negative side allows magnitude 2^31
   always_comb begin
      if (!neg_ff) begin
         tof_sat = (quo > PROD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[T32_W-1:0];
      end else if (quo > PROD_W'(32'h8000_0000)) begin
         tof_sat = 32'h8000_0000;
      end else begin
         tof_sat = ~quo[T32_W-1:0] + 1'b1;
      end
   end

   // ---------------------------------------------------------------- control
   assign out_load = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      poll_low_in   = poll_low_ff;
      seq_in        = seq_ff;
      awaiting_in   = awaiting_ff;
      res_kind_in   = res_kind_ff;
      res_sched_in  = res_sched_ff;
      res_seq_in    = res_seq_ff;
      res_tof_in    = res_tof_ff;
      res_expect_in = res_expect_ff;
      out_valid_in  = out_valid_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_sched_in = '0;
               res_seq_in   = '0;
               res_tof_in   = '0;
               unique case (req_chan.operation)
                  OP_POLL: begin
                     poll_low_in  = rx32;
                     res_sched_in = sched_sum[TS_W-1:SCHED_LSB];
                     res_seq_in   = seq_ff;
                     if (req_chan.transmit_accepted) begin
                        seq_in      = seq_ff + 1'b1;
                        awaiting_in = 1'b1;
                        res_kind_in = KIND_SENT;
                     end else begin
                        awaiting_in = 1'b0;
                        res_kind_in = KIND_FAILED;
                     end
                     state_in = ST_FINISH;
                  end
                  OP_FINAL: begin
                     awaiting_in = 1'b0;
                     state_in    = ST_PREP;
                  end
                  default: begin
                     // bad frame, receive error or unused code
                     awaiting_in = 1'b0;
                     res_kind_in = KIND_ERROR;
                     state_in    = ST_FINISH;
                  end
               endcase
               res_expect_in = awaiting_in;
            end
         end
         ST_PREP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_ab_stat.done && mul_cd_stat.done) begin
               if (den_ff == '0) begin
                  res_kind_in = KIND_INVALID;
                  state_in    = ST_FINISH;
               end else begin
                  state_in = ST_SUB;
               end
            end
         end
         ST_SUB: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_kind_in = KIND_RANGE;
               res_tof_in  = tof_sat;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= '0;
         poll_low_ff  <= '0;
         seq_ff       <= '0;
         awaiting_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         poll_low_ff  <= poll_low_in;
         seq_ff       <= seq_in;
         awaiting_ff  <= awaiting_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            delay_ff <= pwdata;
         end
      end

      res_kind_ff   <= res_kind_in;
      res_sched_ff  <= res_sched_in;
      res_seq_ff    <= res_seq_in;
      res_tof_ff    <= res_tof_in;
      res_expect_ff <= res_expect_in;

      // four wrapped intervals, formed on acceptance
      if (accept) begin
         ra_ff <= req_chan.initiator_resp_rx - req_chan.initiator_poll_tx;
         rb_ff <= rx32 - tx32;
         da_ff <= req_chan.initiator_final_tx - req_chan.initiator_resp_rx;
         db_ff <= tx32 - poll_low_ff;
      end
      if (state_ff == ST_PREP) begin
         den_ff <= {2'b00, ra_ff} + {2'b00, rb_ff} + {2'b00, da_ff} + {2'b00, db_ff};
      end
      if (state_ff == ST_SUB) begin
         neg_ff <= prod_neg;
      end

      if (out_load) begin
         out_kind_ff   <= res_kind_ff;
         out_sched_ff  <= res_sched_ff;
         out_seq_ff    <= res_seq_ff;
         out_tof_ff    <= res_tof_ff;
         out_expect_ff <= res_expect_ff;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.result_kind       = out_kind_ff;
   assign rsp_chan.scheduled_tx_time = out_sched_ff;
   assign rsp_chan.response_sequence = out_seq_ff;
   assign rsp_chan.flight_time_ticks = $signed(out_tof_ff);
   assign rsp_chan.expecting_final   = out_expect_ff;

   // ---------------------------------------------------------------- checks
   `DSTWR_ASSERT_IMPL(a_out_load, $rose(out_valid_ff), $past(out_load), "response without load")
   `DSTWR_ASSERT_IMPL(a_mul_in_mul, mul_busy, state_ff == ST_MUL, "stray multiplier activity")
   `DSTWR_ASSERT_IMPL(a_div_in_div, div_stat.busy, state_ff == ST_DIV, "stray divider activity")
   `DSTWR_ASSERT_NEXT(a_seq_hold, !poll_sent, $stable(seq_ff), "sequence moved without a send")

endmodule

`default_nettype wire
